### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the smoother; they compile to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check cons in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check that expr never holds.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`else

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

### hdl/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Types, constants and control word layout of the pot smoother.
// ----------------------------------------------------------------------------
package mps_pkg;

  localparam int NUM_CHANNELS = 6;
  localparam int HISTORY_LEN  = 16;   // power of two: the average is a shift

  localparam int SAMPLE_W    = 12;
  localparam int CH_OUT_W    = 3;
  localparam int LEVEL_W     = 8;
  localparam int LEVEL_SHIFT = 4;

  localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IDX_W      = $clog2(HISTORY_LEN);
  localparam int HIST_SHIFT = $clog2(HISTORY_LEN);
  localparam int SUM_W      = SAMPLE_W + HIST_SHIFT;
  localparam int MEM_DEPTH  = NUM_CHANNELS * HISTORY_LEN;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_DEADBAND = '0;
  localparam logic [SAMPLE_W-1:0] DEADBAND_RESET = 12'd12;

  // Stream widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;

  // Microprogram
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_WRITE  = 3'd1;
  localparam step_t STEP_PRIME  = 3'd2;
  localparam step_t STEP_SUM    = 3'd3;
  localparam step_t STEP_DRAIN  = 3'd4;
  localparam step_t STEP_FINISH = 3'd5;
  localparam step_t STEP_LAST   = STEP_FINISH;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NO_INPUT,
    COND_IDX_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic  take;      // offer the input channel
    logic  wr;        // write the sample into the history
    logic  rd;        // read history entry at the loop index
    logic  clr;       // clear accumulator and loop index
    logic  acc_en;    // add the returned history word
    logic  finish;    // update held value, issue result, advance indices
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic accept;
    logic wr;
    logic rd;
    logic clr;
    logic acc_en;
    logic finish;
  } dp_ctrl_t;

  typedef struct packed {
    logic idx_last;
  } dp_stat_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] held_value;
    logic [LEVEL_W-1:0]  level;
    logic [CH_OUT_W-1:0] channel;
  } result_t;

endpackage

### hdl/multichannel_pot_smoother.sv
// ----------------------------------------------------------------------------
// multichannel_pot_smoother
// Round-robin moving average with deadband over six converter channels.
// ----------------------------------------------------------------------------
// Usage: send one 12-bit converter request per sample on the s_ side; the
// samples belong to channels 0..5 in turn, starting at channel 0 after reset.
// Each request yields exactly one result on the m_ side: channel number,
// 8-bit level and 12-bit held value of that channel.
// Timing: a request is taken in the idle step; the result is loaded into the
// output register in the finish step. The time per request is set by the
// single-port history memory: one read per cycle over the 16 history
// entries of the channel, plus write, prime, drain and finish steps.
// The next request is accepted while a result waits in the output register.
// Stall: if the receiver holds m_tready low, the sequencer holds in its finish
// step until the output register frees, then returns to idle.
// Reset: history, held values, channel and slot indices clear at once (the
// history through per-entry valid bits, no clearing pass); deadband returns
// to 12. The deadband register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module multichannel_pot_smoother (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mps_pkg::S_TDATA_W-1:0] s_tdata,   // [11:0] sample
  // Output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mps_pkg::M_TDATA_W-1:0] m_tdata,   // [2:0] channel, [10:3] level,
                                                    // [22:11] held_value
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mps_pkg::PADDR_W-1:0]   paddr,
  input  logic [mps_pkg::PDATA_W-1:0]   pwdata,
  output logic [mps_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  mps_pkg::dp_ctrl_t            ctrl;
  mps_pkg::dp_stat_t            stat;
  mps_pkg::result_t             result;
  logic [mps_pkg::SAMPLE_W-1:0] deadband;
  logic                         out_free;
  logic                         reg_hit;

  // Register decode: word address only, byte lanes ignored
  assign pready  = 1'b1;
  assign reg_hit = (paddr[mps_pkg::PADDR_W-1:2] == mps_pkg::REG_DEADBAND);
  assign prdata  = reg_hit ? mps_pkg::PDATA_W'(deadband) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= mps_pkg::DEADBAND_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      deadband <= pwdata[mps_pkg::SAMPLE_W-1:0];
    end
  end

  // Output register frees when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;

  mps_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (s_tready),
    .ctrl     (ctrl)
  );

  mps_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .sample   (s_tdata[mps_pkg::SAMPLE_W-1:0]),
    .deadband (deadband),
    .stat     (stat),
    .result   (result)
  );

  // Result register: load on finish, drop on handoff
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      m_tdata <= mps_pkg::M_TDATA_W'(result);
    end
  end

endmodule

### hdl/mps_seq.sv
// ----------------------------------------------------------------------------
// mps_seq
// Step counter and microprogram ROM driving the smoother datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mps_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_free,
  input  mps_pkg::dp_stat_t stat,
  output logic              in_ready,
  output mps_pkg::dp_ctrl_t ctrl
);

  mps_pkg::step_t      step;
  mps_pkg::step_t      step_next;
  mps_pkg::ctrl_word_t cw;
  logic                cond_true;

  // Microprogram
  always_comb begin
    cw = '{take: 1'b0, wr: 1'b0, rd: 1'b0, clr: 1'b0, acc_en: 1'b0, finish: 1'b0,
           cond: mps_pkg::COND_NONE, target: mps_pkg::STEP_IDLE};
    case (step)
      mps_pkg::STEP_IDLE: begin
        cw.take   = 1'b1;
        cw.cond   = mps_pkg::COND_NO_INPUT;
        cw.target = mps_pkg::STEP_IDLE;
      end
      mps_pkg::STEP_WRITE: begin
        cw.wr  = 1'b1;
        cw.clr = 1'b1;
      end
      mps_pkg::STEP_PRIME: begin
        cw.rd = 1'b1;
      end
      mps_pkg::STEP_SUM: begin
        cw.rd     = 1'b1;
        cw.acc_en = 1'b1;
        cw.cond   = mps_pkg::COND_IDX_MORE;
        cw.target = mps_pkg::STEP_SUM;
      end
      mps_pkg::STEP_DRAIN: begin
        cw.acc_en = 1'b1;
      end
      mps_pkg::STEP_FINISH: begin
        cw.finish = 1'b1;
        cw.cond   = mps_pkg::COND_OUT_BUSY;
        cw.target = mps_pkg::STEP_FINISH;
      end
      default: begin
        cw.cond   = mps_pkg::COND_NONE;
      end
    endcase
  end

  always_comb begin
    case (cw.cond)
      mps_pkg::COND_NO_INPUT: cond_true = !in_valid;
      mps_pkg::COND_IDX_MORE: cond_true = !stat.idx_last;
      mps_pkg::COND_OUT_BUSY: cond_true = !out_free;
      default:                cond_true = 1'b0;
    endcase

    if (cond_true) begin
      step_next = cw.target;
    end else if (step >= mps_pkg::STEP_LAST) begin
      step_next = mps_pkg::STEP_IDLE;
    end else begin
      step_next = step + 1'b1;
    end

    in_ready    = cw.take;
    ctrl.accept = cw.take && in_valid;
    ctrl.wr     = cw.wr;
    ctrl.rd     = cw.rd;
    ctrl.clr    = cw.clr;
    ctrl.acc_en = cw.acc_en;
    ctrl.finish = cw.finish && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= mps_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  `ASSERT_NEXT(a_accept_to_write, clk, rst, ctrl.accept, step == mps_pkg::STEP_WRITE,
               "accepted request did not start the write step")
  `ASSERT_NEXT(a_stall_holds, clk, rst, cw.finish && !out_free,
               step == mps_pkg::STEP_FINISH, "finish step left while output was full")
  `ASSERT_NEXT(a_finish_to_idle, clk, rst, ctrl.finish, step == mps_pkg::STEP_IDLE,
               "sequencer did not return to idle after a result")
  `ASSERT_NEVER(a_step_range, clk, rst, step > mps_pkg::STEP_LAST,
                "step counter beyond end of program")

endmodule

### hdl/mps_datapath.sv
// ----------------------------------------------------------------------------
// mps_datapath
// History memory, accumulator, held values and channel/slot indices.
// ----------------------------------------------------------------------------
module mps_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  mps_pkg::dp_ctrl_t              ctrl,
  input  logic [mps_pkg::SAMPLE_W-1:0]   sample,
  input  logic [mps_pkg::SAMPLE_W-1:0]   deadband,
  output mps_pkg::dp_stat_t              stat,
  output mps_pkg::result_t               result
);

  logic [mps_pkg::SAMPLE_W-1:0]  hist [mps_pkg::MEM_DEPTH];
  logic [mps_pkg::MEM_DEPTH-1:0] hist_vld;
  logic [mps_pkg::SAMPLE_W-1:0]  rd_data;
  logic                          rd_vld;

  logic [mps_pkg::SAMPLE_W-1:0]  held [mps_pkg::NUM_CHANNELS];
  logic [mps_pkg::SAMPLE_W-1:0]  sample_q;
  logic [mps_pkg::CH_W-1:0]      ch;
  logic [mps_pkg::IDX_W-1:0]     slot;
  logic [mps_pkg::IDX_W-1:0]     idx;
  logic [mps_pkg::SUM_W-1:0]     acc;

  logic [mps_pkg::ADDR_W-1:0]    wr_addr;
  logic [mps_pkg::ADDR_W-1:0]    rd_addr;
  logic [mps_pkg::SAMPLE_W-1:0]  avg;
  logic [mps_pkg::SAMPLE_W-1:0]  held_cur;
  logic [mps_pkg::SAMPLE_W-1:0]  diff;
  logic [mps_pkg::SAMPLE_W-1:0]  held_new;

  assign wr_addr = mps_pkg::ADDR_W'(ch) * mps_pkg::ADDR_W'(mps_pkg::HISTORY_LEN)
                 + mps_pkg::ADDR_W'(slot);
  assign rd_addr = mps_pkg::ADDR_W'(ch) * mps_pkg::ADDR_W'(mps_pkg::HISTORY_LEN)
                 + mps_pkg::ADDR_W'(idx);

  assign stat.idx_last = (idx == mps_pkg::IDX_W'(mps_pkg::HISTORY_LEN - 1));

  // Average and deadband decision
  always_comb begin
    avg      = mps_pkg::SAMPLE_W'(acc >> mps_pkg::HIST_SHIFT);
    held_cur = held[ch];
    diff     = (held_cur > avg) ? (held_cur - avg) : (avg - held_cur);
    held_new = (diff >= deadband) ? avg : held_cur;

    result.channel    = mps_pkg::CH_OUT_W'(ch);
    result.level      = mps_pkg::LEVEL_W'(held_new >> mps_pkg::LEVEL_SHIFT);
    result.held_value = held_new;
  end

  // History memory
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      hist[wr_addr] <= sample_q;
    end
    if (ctrl.rd) begin
      rd_data <= hist[rd_addr];
    end
  end

  // Entry valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (ctrl.wr) begin
        hist_vld[wr_addr] <= 1'b1;
      end
      if (ctrl.rd) begin
        rd_vld <= hist_vld[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      sample_q <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + (rd_vld ? mps_pkg::SUM_W'(rd_data) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctrl.clr) begin
      idx <= '0;
    end else if (ctrl.rd) begin
      idx <= idx + 1'b1;
    end
  end

  // Held values and round-robin indices
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mps_pkg::NUM_CHANNELS; i++) begin
        held[i] <= '0;
      end
      ch   <= '0;
      slot <= '0;
    end else if (ctrl.finish) begin
      held[ch] <= held_new;
      if (ch == mps_pkg::CH_W'(mps_pkg::NUM_CHANNELS - 1)) begin
        ch <= '0;
        if (slot == mps_pkg::IDX_W'(mps_pkg::HISTORY_LEN - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + 1'b1;
        end
      end else begin
        ch <= ch + 1'b1;
      end
    end
  end

endmodule

### dv/multichannel_pot_smoother_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_pot_smoother_tb
// Self-checking bench for the round-robin pot smoother. Converter readings
// go in on the s_ stream. A scoreboard keeps its own copy of the per-channel
// histories, held values and deadband, and predicts each result. Results on
// the m_ stream are checked field by field in order. The deadband is
// rewritten over APB between phases, its extremes included. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------

// Tracks history and held values per channel; queues the predicted results.
class smoother_scoreboard;
  logic [11:0]          history [mps_pkg::NUM_CHANNELS][mps_pkg::HISTORY_LEN];
  logic [11:0]          held [mps_pkg::NUM_CHANNELS];
  int unsigned          chan;
  int unsigned          slot;
  logic [11:0]          deadband;
  mps_pkg::result_t     held_queue [$];
  int unsigned          failures;

  function new();
    foreach (history[c, i]) history[c][i] = '0;
    foreach (held[c]) held[c] = '0;
    chan      = 0;
    slot      = 0;
    deadband  = mps_pkg::DEADBAND_RESET;
    failures  = 0;
  endfunction

  function void set_deadband(logic [11:0] value);
    deadband = value;
  endfunction

  function int pending();
    return held_queue.size();
  endfunction

  function void mismatch(string what, int unsigned want, int unsigned got);
    failures++;
    if (failures <= 10)
      $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
  endfunction

  // Store the reading, average the channel history, apply the deadband.
  function void track_reading(logic [11:0] reading);
    int unsigned      total;
    logic [11:0]      avg;
    logic [11:0]      diff;
    mps_pkg::result_t res;
    total = 0;
    history[chan][slot] = reading;
    for (int i = 0; i < mps_pkg::HISTORY_LEN; i++) total += history[chan][i];
    avg  = 12'(total / mps_pkg::HISTORY_LEN);
    diff = (held[chan] > avg) ? held[chan] - avg : avg - held[chan];
    if (diff >= deadband) held[chan] = avg;
    res.channel    = 3'(chan);
    res.level      = 8'(held[chan] >> mps_pkg::LEVEL_SHIFT);
    res.held_value = held[chan];
    held_queue.push_back(res);
    chan++;
    if (chan == mps_pkg::NUM_CHANNELS) begin
      chan = 0;
      slot = (slot + 1) % mps_pkg::HISTORY_LEN;
    end
  endfunction

  function void check_result(logic [mps_pkg::M_TDATA_W-1:0] word);
    mps_pkg::result_t got;
    mps_pkg::result_t want;
    got = word[22:0];
    if (held_queue.size() == 0) begin
      mismatch("unexpected result (tdata)", 0, word);
      return;
    end
    want = held_queue.pop_front();
    if (got.channel !== want.channel) mismatch("channel", want.channel, got.channel);
    if (got.level !== want.level) mismatch("level", want.level, got.level);
    if (got.held_value !== want.held_value)
      mismatch("held_value", want.held_value, got.held_value);
    if (word[23] !== 1'b0) mismatch("tdata padding", 0, word[23]);
  endfunction
endclass

module multichannel_pot_smoother_tb;
  import mps_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = 24;    // longer than one request takes
  localparam int PHASE_ITEMS  = 290;
  localparam int RAND_PHASES  = 6;
  localparam logic [PADDR_W-1:0] DEADBAND_ADDR = {REG_DEADBAND, 2'b00};
  localparam logic [11:0] FULL_SCALE = 12'hFFF;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;     // [11:0] sample
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;     // [2:0] channel, [10:3] level, [22:11] held_value
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  smoother_scoreboard   sb;
  int unsigned          cycles;
  bit                   src_idle_on;
  bit                   snk_idle_on;
  int                   pot_pos [NUM_CHANNELS];
  int unsigned          next_chan;     // channel the next request belongs to

  multichannel_pot_smoother dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 8 ns clock.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bound the run: a hang anywhere ends in a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[multichannel_pot_smoother] ERROR");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int draw_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Pot-like reading: a slowly drifting knob with a little converter noise,
  // with the odd jump, sometimes to a rail.
  function automatic logic [11:0] pot_reading(int ch);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 4)       pot_pos[ch] = $urandom_range(0, 4095);
    else if (r < 6)  pot_pos[ch] = $urandom_range(0, 1) ? 4095 : 0;
    else if (r < 30) pot_pos[ch] += $urandom_range(0, 80) - 40;
    if (pot_pos[ch] < 0) pot_pos[ch] = 0;
    if (pot_pos[ch] > 4095) pot_pos[ch] = 4095;
    v = pot_pos[ch] + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // Mostly pot behavior, some raw noise, some rail and midscale values.
  function automatic logic [11:0] next_reading(int ch);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return pot_reading(ch);
    if (r < 90) return 12'($urandom);
    case ($urandom_range(0, 3))
      0:       return 12'h000;
      1:       return FULL_SCALE;
      2:       return 12'h800;
      default: return 12'h7FF;
    endcase
  endfunction

  // Offer one request; called and returning at a falling edge. Keep tvalid
  // high across back-to-back requests so it is never dropped and raised in
  // one step.
  task automatic send_reading(logic [11:0] reading);
    int gap;
    gap = draw_gap(src_idle_on);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {4'b0000, reading};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.track_reading(reading);
    next_chan = (next_chan + 1) % NUM_CHANNELS;
    @(negedge clk);
  endtask

  // Hold the sender until every expected result is back, then let the
  // sequencer settle.
  task automatic drain(int settle);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // APB write then read-back of the deadband; only while the block is idle.
  task automatic set_deadband(logic [11:0] value);
    logic [PDATA_W-1:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = DEADBAND_ADDR;
    pwdata  = PDATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_deadband(value);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got[11:0] !== value) sb.mismatch("deadband read-back", value, got[11:0]);
  endtask

  // Rails, checkerboards, midscale and end-bit patterns: every sample bit both ways.
  task automatic send_edge_cases();
    logic [11:0] edges [12];
    edges = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h800, 12'h7FF,
              12'h001, 12'hFFE, 12'h0F0, 12'hF0F, 12'h000, 12'hFFF};
    foreach (edges[i]) send_reading(edges[i]);
  endtask

  // Receiver: stall at random, drop stalls entirely in some phases, and
  // check every result taken.
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready   = 1'b1;
        stall_left = draw_gap(snk_idle_on);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin
    logic [11:0] phase_deadband;
    sb           = new();
    cycles       = 0;
    next_chan    = 0;
    src_idle_on  = 1'b1;
    snk_idle_on  = 1'b1;
    foreach (pot_pos[c]) pot_pos[c] = $urandom_range(0, 4095);
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Out of reset: histories and held values start at zero, deadband 12,
    // so averages creep up from zero.
    send_edge_cases();
    drain(SETTLE);

    // Zero deadband: every average replaces the held value.
    set_deadband(12'd0);
    send_edge_cases();
    drain(SETTLE);

    // Maximum deadband: only a full swing between the rails moves the held
    // value. Fill every history with full scale, then empty it again.
    set_deadband(FULL_SCALE);
    repeat (NUM_CHANNELS * HISTORY_LEN) send_reading(FULL_SCALE);
    repeat (NUM_CHANNELS * HISTORY_LEN) send_reading(12'h000);
    drain(SETTLE);

    // Random phases over several deadbands; vary which side idles so some
    // stretches run at full rate.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       phase_deadband = 12'd0;
        1:       phase_deadband = FULL_SCALE;
        2:       phase_deadband = DEADBAND_RESET;
        3:       phase_deadband = 12'($urandom_range(1, 64));
        4:       phase_deadband = 12'($urandom_range(100, 4094));
        default: phase_deadband = 12'($urandom);
      endcase
      set_deadband(phase_deadband);
      src_idle_on = (ph % 3 != 1);
      snk_idle_on = (ph % 3 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through, hold off until the pipeline is empty.
        if (n == PHASE_ITEMS / 2) drain(0);
        send_reading(next_reading(next_chan));
      end
      drain(SETTLE);
    end

    // Everything sent: wait for stragglers, then a margin for stray results.
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[multichannel_pot_smoother] OK");
    end else begin
      $display("[multichannel_pot_smoother] ERROR");
    end
    $finish;
  end
endmodule
